// ===== rtl/crc_pkg.sv =====
`default_nettype none
package crc_pkg;

  // Card geometry: two 12-bit columns share one row of the column store
  localparam int CARD_COLUMNS = 80;
  localparam int COL_W        = 12;
  localparam int ROW_W        = 2 * COL_W;
  localparam int ROWS         = (CARD_COLUMNS + 1) / 2;
  localparam int AW           = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW           = $clog2(CARD_COLUMNS + 1);

  // Stream widths
  localparam int IN_DW  = 56;
  localparam int IN_UW  = 3;
  localparam int OUT_DW = 48;

  // Configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 16;
  localparam logic [CFG_IW-1:0] CFG_TRANSFER_ADDR  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_TRANSFER_COUNT = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_ZIO_FLAG       = 2'd2;

  // Request kinds on the input stream
  localparam logic [2:0] REQ_WRITE  = 3'd0;
  localparam logic [2:0] REQ_STATUS = 3'd1;
  localparam logic [2:0] REQ_BYTE   = 3'd2;
  localparam logic [2:0] REQ_POLL   = 3'd3;
  localparam logic [2:0] REQ_ATTACH = 3'd4;

  // Classified operations passed from front to back
  localparam logic [2:0] OP_WRITE  = 3'd0;
  localparam logic [2:0] OP_READ   = 3'd1;
  localparam logic [2:0] OP_BYTE   = 3'd2;
  localparam logic [2:0] OP_POLL   = 3'd3;
  localparam logic [2:0] OP_ATTACH = 3'd4;
  localparam logic [2:0] OP_ERROR  = 3'd5;
  localparam logic [2:0] OP_NONE   = 3'd6;

  // E register selects
  localparam logic [7:0] E_WRITE = 8'd7;
  localparam logic [7:0] E_READ  = 8'd17;

  // Mode field of the write command
  localparam logic [1:0] MODE_EBCDIC = 2'd2;
  localparam logic [1:0] MODE_IDLE   = 2'd3;

  // Status bits
  localparam logic [15:0] ST_STOP    = 16'h0004;
  localparam logic [15:0] ST_EMPTY   = 16'h0040;
  localparam logic [15:0] ST_MISSING = 16'h0080;
  localparam logic [15:0] ST_EBCDIC  = 16'h0001;

  // Rows 1-7 of a column
  localparam logic [COL_W-1:0] PUNCH_MASK = 12'h1FC;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  mode;
    logic [7:0]  cbyte;
    logic [17:0] deck;
  } cmd_t;

  typedef struct packed {
    logic [15:0] transfer_addr;
    logic [15:0] transfer_count;
    logic        zio_flag;
  } cfg_t;

  // Lowest field last, so the packed word matches the stream layout
  typedef struct packed {
    logic        busy_res;
    logic        io_error;
    logic        irq;
    logic        mem_zio;
    logic [7:0]  mem_byte;
    logic [15:0] mem_address;
    logic        mem_write;
    logic [15:0] read_data;
  } result_t;

  localparam int RES_W = $bits(result_t);

endpackage
`default_nettype wire

// ===== rtl/card_reader_controller.sv =====
`default_nettype none
// Card reader controller.
// Input stream in_*: one request per transfer; in_tuser carries the request
// kind (write command, status read, card byte, poll tick, deck attach) and
// in_tdata its operands. Every request gives exactly one result on out_*,
// which carries the status read data, the memory write of a poll, the
// interrupt pulse, the E register error and the busy flag.
// Configuration port cfg_*: transfer address, byte count and shared memory flag; the
// user must write it only while no request is in flight, which the block does not enforce.
// A request waits in the queue and its result is registered. Throughput: one
// request per cycle while the receiver does not stall; the back end executes one
// request per cycle, and polls prefetch the column store two rows ahead of the
// column pointer, so consecutive polls never wait on the store's read port.
// A two-entry queue separates the request side from execution; when the
// receiver stalls, the result register holds, the queue fills and in_tready
// drops after two more requests.
// Reset empties the queue, clears status, hopper count, card load and
// transfer state. The column store needs no clearing pass: it is read only
// after a full card has been written.
module card_reader_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // e_select[7:0], write_value[23:8], card_byte[31:24], deck_size[49:32]
  input  logic [crc_pkg::IN_DW-1:0]     in_tdata,
  // req_type[2:0]
  input  logic [crc_pkg::IN_UW-1:0]     in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // read_data[15:0], mem_write[16], mem_address[32:17], mem_byte[40:33],
  // mem_zio[41], irq[42], io_error[43], busy_res[44]
  output logic [crc_pkg::OUT_DW-1:0]    out_tdata,
  input  logic                          cfg_we,
  input  logic [crc_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [crc_pkg::CFG_DW-1:0]    cfg_wdata
);
  import crc_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  cmd_t    f_cmd;
  cmd_t    q_cmd;
  logic    q_valid;
  logic    q_pop;
  result_t res;

  // Write configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_TRANSFER_ADDR:  cfg_nxt.transfer_addr  = cfg_wdata;
        CFG_TRANSFER_COUNT: cfg_nxt.transfer_count = cfg_wdata;
        CFG_ZIO_FLAG:       cfg_nxt.zio_flag       = cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  crc_front u_front (
    .req_type    (in_tuser[2:0]),
    .e_select    (in_tdata[7:0]),
    .write_value (in_tdata[23:8]),
    .card_byte   (in_tdata[31:24]),
    .deck_size   (in_tdata[49:32]),
    .cmd         (f_cmd)
  );

  crc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (f_cmd),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_cmd   (q_cmd)
  );

  crc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {(OUT_DW - RES_W)'(0), res};

endmodule
`default_nettype wire

// ===== rtl/crc_ram.sv =====
`default_nettype none
module crc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 40,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/crc_front.sv =====
`default_nettype none
module crc_front (
  input  logic [2:0]    req_type,
  input  logic [7:0]    e_select,
  input  logic [15:0]   write_value,
  input  logic [7:0]    card_byte,
  input  logic [17:0]   deck_size,
  output crc_pkg::cmd_t cmd
);
  import crc_pkg::*;

  // Classify the request and check the E register
  always_comb begin
    cmd.mode  = write_value[15:14];
    cmd.cbyte = card_byte;
    cmd.deck  = deck_size;
    case (req_type)
      REQ_WRITE:  cmd.op = (e_select == E_WRITE) ? OP_WRITE : OP_ERROR;
      REQ_STATUS: cmd.op = (e_select == E_READ) ? OP_READ : OP_ERROR;
      REQ_BYTE:   cmd.op = OP_BYTE;
      REQ_POLL:   cmd.op = OP_POLL;
      REQ_ATTACH: cmd.op = OP_ATTACH;
      default:    cmd.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/crc_queue.sv =====
`default_nettype none
module crc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  crc_pkg::cmd_t in_cmd,
  output logic          out_valid,
  input  logic          out_pop,
  output crc_pkg::cmd_t out_cmd
);
  import crc_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;

  assign in_ready  = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_cmd   = entry_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_pop && out_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold request payloads
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/crc_back.sv =====
`default_nettype none
module crc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  crc_pkg::cfg_t    cfg,
  input  logic             q_valid,
  input  crc_pkg::cmd_t    q_cmd,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output crc_pkg::result_t out_res
);
  import crc_pkg::*;

  // Card loading
  logic [CW-1:0]    load_count_r, load_count_nxt;
  logic [1:0]       load_phase_r, load_phase_nxt;
  logic [7:0]       part0_r, part0_nxt;
  logic [7:0]       part1_r, part1_nxt;
  logic             card_ready_r, card_ready_nxt;
  // Transfer
  logic             active_r, active_nxt;
  logic             ebcdic_r, ebcdic_nxt;
  logic [15:0]      status_r, status_nxt;
  logic [1:0]       byte_phase_r, byte_phase_nxt;
  logic [CW-1:0]    col_ptr_r, col_ptr_nxt;
  logic [15:0]      cur_addr_r, cur_addr_nxt;
  logic [15:0]      bytes_rem_r, bytes_rem_nxt;
  logic [17:0]      hopper_r, hopper_nxt;
  // Column window: current row, next row, prefetch from the store
  logic [ROW_W-1:0] cur_row_r, cur_row_nxt;
  logic [ROW_W-1:0] nxt_row_r, nxt_row_nxt;
  logic             nxt_ram_r, nxt_ram_nxt;
  logic             nxt_oob_r, nxt_oob_nxt;
  logic [ROW_W-1:0] row0_r, row1_r;
  // Output register
  logic             out_valid_r, out_valid_nxt;
  result_t          res_r, res_nxt;

  logic             exec;
  logic [ROW_W-1:0] nxt_eff;
  logic [COL_W-1:0] col_a, col_b;
  logic [COL_W-1:0] punch;
  logic             multi_punch;
  logic [CW-1:0]    row_sum;
  logic             rd_oob;
  logic [CW:0]      lc_p1, lc_p2, ptr_p1;
  logic             first_last;
  logic [COL_W-1:0] col1, col2;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;
  logic             adv;
  logic [7:0]       mbyte;
  logic [15:0]      rem_dec;

  crc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign exec      = q_valid && (!out_valid_r || out_ready);
  assign q_pop     = exec;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // Select the columns at the pointer and after it
  assign nxt_eff = nxt_ram_r ? (nxt_oob_r ? '0 : ram_rdata) : nxt_row_r;
  assign col_a   = col_ptr_r[0] ? cur_row_r[ROW_W-1:COL_W] : cur_row_r[COL_W-1:0];
  assign col_b   = col_ptr_r[0] ? nxt_eff[COL_W-1:0] : cur_row_r[ROW_W-1:COL_W];
  assign punch       = col_a & PUNCH_MASK;
  assign multi_punch = (punch & (punch - 12'd1)) != 12'd0;
  assign ptr_p1      = {1'b0, col_ptr_r} + (CW+1)'(1);
  assign rem_dec     = bytes_rem_r - 16'd1;

  // Prefetch the row two ahead of the pointer
  assign row_sum   = {1'b0, col_ptr_r[CW-1:1]} + CW'(2);
  assign rd_oob    = row_sum >= CW'(ROWS);
  assign ram_raddr = row_sum[AW-1:0];

  // Unpack a byte triple into two columns
  assign col1       = {part0_r, part1_r[7:4]};
  assign col2       = {part1_r[3:0], q_cmd.cbyte};
  assign lc_p1      = {1'b0, load_count_r} + (CW+1)'(1);
  assign lc_p2      = {1'b0, load_count_r} + (CW+1)'(2);
  assign first_last = lc_p1 >= (CW+1)'(CARD_COLUMNS);
  assign ram_waddr  = load_count_r[AW:1];
  assign ram_wdata  = {(first_last ? {COL_W{1'b0}} : col2), col1};

  always_comb begin
    load_count_nxt = load_count_r;
    load_phase_nxt = load_phase_r;
    part0_nxt      = part0_r;
    part1_nxt      = part1_r;
    card_ready_nxt = card_ready_r;
    active_nxt     = active_r;
    ebcdic_nxt     = ebcdic_r;
    status_nxt     = status_r;
    byte_phase_nxt = byte_phase_r;
    col_ptr_nxt    = col_ptr_r;
    cur_addr_nxt   = cur_addr_r;
    bytes_rem_nxt  = bytes_rem_r;
    hopper_nxt     = hopper_r;
    cur_row_nxt    = cur_row_r;
    nxt_row_nxt    = nxt_eff;
    nxt_ram_nxt    = 1'b0;
    nxt_oob_nxt    = 1'b0;
    ram_we         = 1'b0;
    adv            = 1'b0;
    mbyte          = 8'd0;
    res_nxt        = '0;

    if (exec) begin
      case (q_cmd.op)
        // Decode the mode and start a transfer, or report stop, empty hopper or missing card
        OP_WRITE: begin
          if (!active_r) begin
            if (q_cmd.mode == MODE_IDLE) begin
              status_nxt  = ST_STOP;
              res_nxt.irq = 1'b1;
            end else if (hopper_r == 18'd0) begin
              status_nxt  = ST_EMPTY;
              res_nxt.irq = 1'b1;
            end else if (!card_ready_r) begin
              status_nxt  = ST_MISSING;
              res_nxt.irq = 1'b1;
            end else begin
              ebcdic_nxt     = (q_cmd.mode == MODE_EBCDIC);
              cur_addr_nxt   = cfg.transfer_addr;
              bytes_rem_nxt  = cfg.transfer_count;
              col_ptr_nxt    = '0;
              byte_phase_nxt = 2'd0;
              active_nxt     = 1'b1;
              cur_row_nxt    = row0_r;
              nxt_row_nxt    = (ROWS > 1) ? row1_r : '0;
            end
          end
        end
        // Return status and clear it
        OP_READ: begin
          res_nxt.read_data = status_r;
          status_nxt        = 16'd0;
        end
        OP_ERROR: begin
          res_nxt.io_error = 1'b1;
        end
        // Collect card bytes and store a column pair per triple
        OP_BYTE: begin
          if (!card_ready_r) begin
            if (load_phase_r != 2'd2) begin
              if (load_phase_r == 2'd0) begin
                part0_nxt = q_cmd.cbyte;
              end else begin
                part1_nxt = q_cmd.cbyte;
              end
              load_phase_nxt = load_phase_r + 2'd1;
            end else begin
              ram_we         = 1'b1;
              load_phase_nxt = 2'd0;
              if (first_last) begin
                load_count_nxt = lc_p1[CW-1:0];
                card_ready_nxt = 1'b1;
              end else begin
                load_count_nxt = lc_p2[CW-1:0];
                card_ready_nxt = lc_p2 >= (CW+1)'(CARD_COLUMNS);
              end
            end
          end
        end
        // Emit one memory byte
        OP_POLL: begin
          if (active_r) begin
            if (ebcdic_r) begin
              adv = 1'b1;
              if (multi_punch) begin
                mbyte      = 8'd0;
                status_nxt = status_r | ST_EBCDIC;
              end else begin
                mbyte = col_a[7:0];
              end
            end else begin
              case (byte_phase_r)
                2'd0: begin
                  mbyte          = col_a[11:4];
                  byte_phase_nxt = 2'd1;
                end
                2'd1: begin
                  mbyte          = {col_a[3:0], col_b[11:8]};
                  adv            = 1'b1;
                  byte_phase_nxt = 2'd2;
                end
                default: begin
                  mbyte          = col_a[7:0];
                  adv            = 1'b1;
                  byte_phase_nxt = 2'd0;
                end
              endcase
            end
            // Slide the window when the pointer crosses into the next row
            if (adv) begin
              col_ptr_nxt = ptr_p1[CW-1:0];
              if (col_ptr_r[0]) begin
                cur_row_nxt = nxt_eff;
                nxt_ram_nxt = 1'b1;
                nxt_oob_nxt = rd_oob;
              end
            end
            res_nxt.mem_write   = 1'b1;
            res_nxt.mem_address = cur_addr_r;
            res_nxt.mem_byte    = mbyte;
            res_nxt.mem_zio     = cfg.zio_flag;
            cur_addr_nxt        = cur_addr_r + 16'd1;
            bytes_rem_nxt       = rem_dec;
            // End of transfer: drop the card and interrupt
            if (rem_dec == 16'd0 || (adv && ptr_p1 >= (CW+1)'(CARD_COLUMNS))) begin
              active_nxt = 1'b0;
              if (hopper_r != 18'd0) begin
                hopper_nxt = hopper_r - 18'd1;
              end
              card_ready_nxt = 1'b0;
              load_count_nxt = '0;
              load_phase_nxt = 2'd0;
              if ((status_nxt & ST_EBCDIC) == 16'd0) begin
                status_nxt = 16'd0;
              end
              res_nxt.irq = 1'b1;
            end
          end
        end
        // Attach a new deck
        OP_ATTACH: begin
          hopper_nxt     = q_cmd.deck;
          status_nxt     = 16'd0;
          active_nxt     = 1'b0;
          card_ready_nxt = 1'b0;
          load_count_nxt = '0;
          load_phase_nxt = 2'd0;
        end
        default: begin
        end
      endcase
    end
    res_nxt.busy_res = active_nxt;

    out_valid_nxt = exec ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
      load_phase_r <= 2'd0;
      part0_r      <= 8'd0;
      part1_r      <= 8'd0;
      card_ready_r <= 1'b0;
      active_r     <= 1'b0;
      ebcdic_r     <= 1'b0;
      status_r     <= 16'd0;
      byte_phase_r <= 2'd0;
      col_ptr_r    <= '0;
      cur_addr_r   <= 16'd0;
      bytes_rem_r  <= 16'd0;
      hopper_r     <= 18'd0;
      nxt_ram_r    <= 1'b0;
      nxt_oob_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      load_count_r <= load_count_nxt;
      load_phase_r <= load_phase_nxt;
      part0_r      <= part0_nxt;
      part1_r      <= part1_nxt;
      card_ready_r <= card_ready_nxt;
      active_r     <= active_nxt;
      ebcdic_r     <= ebcdic_nxt;
      status_r     <= status_nxt;
      byte_phase_r <= byte_phase_nxt;
      col_ptr_r    <= col_ptr_nxt;
      cur_addr_r   <= cur_addr_nxt;
      bytes_rem_r  <= bytes_rem_nxt;
      hopper_r     <= hopper_nxt;
      nxt_ram_r    <= nxt_ram_nxt;
      nxt_oob_r    <= nxt_oob_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload: window rows, first two rows of the card, result
  always_ff @(posedge clk) begin
    cur_row_r <= cur_row_nxt;
    nxt_row_r <= nxt_row_nxt;
    if (ram_we && load_count_r[CW-1:1] == (CW-1)'(0)) begin
      row0_r <= ram_wdata;
    end
    if (ram_we && load_count_r[CW-1:1] == (CW-1)'(1)) begin
      row1_r <= ram_wdata;
    end
    if (exec) begin
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/crc_checker.sv =====
`default_nettype none
module crc_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [crc_pkg::OUT_DW-1:0] out_tdata
);

  // No result survives reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Memory fields are zero without a memory write
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[16] |-> out_tdata[41:17] == 25'd0)
    else $error("memory fields set without a write");

  // The write that ends a transfer raises the interrupt
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16] && !out_tdata[44] |-> out_tdata[42])
    else $error("transfer ended without interrupt");

  // A wrong E register leaves every result field below the error flag zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[43] |-> out_tdata[42:0] == 43'd0)
    else $error("error result carries data");

endmodule

bind card_reader_controller crc_checker u_crc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
